[hw/rtl/oai_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array package
// Command and status codes, controller states and the shift control that the
// top level hands to every storage cell.
// ----------------------------------------------------------------------------
package oai_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  // A range erase moves the list by at most sixteen places, one per cycle.
  localparam int STEP_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND      = 3'd0,
    CMD_REMOVE_LAST = 3'd1,
    CMD_INSERT      = 3'd2,
    CMD_ERASE_ONE   = 3'd3,
    CMD_ERASE_RANGE = 3'd4,
    CMD_READ        = 3'd5,
    CMD_CLEAR       = 3'd6,
    CMD_NOP         = 3'd7
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // One shift step for the whole row of cells.
  typedef struct packed {
    logic up;    // open a gap at the target position
    logic down;  // close the gap at the target position
  } shift_ctrl_t;

endpackage

[hw/rtl/ordered_array_insert_erase.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array with insert and erase
// An ordered list of up to DEPTH words kept in a row of cells. Insert and
// erase move the tail of the list one place per cycle through the row.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   --------  ---------------  ---------------------------------------------
//   request   start / busy     command, position, last_position, value
//   result    done (strobe)    read_value, entry_count, status
//
// A request is taken on a rising edge where start is high and busy is low.
// The cycle after that, every cell moves by at most one place; a range erase
// repeats that step once per removed entry, all other commands take one
// step. The result then shows on the result ports for one cycle under done,
// and in that same cycle busy is already low again, so the next request may
// be taken while done is high.
// The receiver cannot stall; results are never held back.
// Reset clears the count, the controller and the strobe. Cell contents are not
// reset: an entry is only ever read after it has been written.
//
module ordered_array_insert_erase
  import oai_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command,
  input  logic [POS_W-1:0]    position,
  input  logic [POS_W-1:0]    last_position,
  input  logic [VALUE_W-1:0]  value,
  output logic                done,
  output logic [VALUE_W-1:0]  read_value,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [STATUS_W-1:0] status
);

  // The count must be able to hold DEPTH itself. Comparisons run at a width
  // that also covers the four-bit positions and a gap of sixteen.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > STEP_W) ? CNT_W : STEP_W;
  // Positions are four bits, so only the first sixteen cells can be read.
  localparam int RD_N  = (DEPTH < 16) ? DEPTH : 16;

  // ---------------------------------------------------------------------------
  // Stored state and request registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]     count;
  state_t               state;
  state_t               state_next;

  logic [CMP_W-1:0]     target;
  logic [WORD_BITS-1:0] new_word;
  logic                 up_op;
  logic                 down_op;
  logic                 read_op;
  logic [STEP_W-1:0]    steps;
  status_t              result_status;
  logic [CNT_W-1:0]     count_after;

  logic                 accept;
  logic                 last_step;
  shift_ctrl_t          shift;

  // ---------------------------------------------------------------------------
  // Request decode. All bounds checks happen here, on the edge the request is
  // taken, so that the execute cycles only have to move words.
  // ---------------------------------------------------------------------------
  command_t             cmd;
  logic [CMP_W-1:0]     cnt_c;
  logic [CMP_W-1:0]     pos_c;
  logic [CMP_W-1:0]     last_c;
  logic [CMP_W-1:0]     depth_c;
  logic [STEP_W-1:0]    gap;
  logic [CMP_W-1:0]     dec_target;
  logic                 dec_up;
  logic                 dec_down;
  logic                 dec_read;
  logic [STEP_W-1:0]    dec_steps;
  status_t              dec_status;
  logic [CMP_W-1:0]     dec_count;
  logic [WORD_BITS+VALUE_W-1:0] value_wide;

  assign cmd     = command_t'(command);
  assign cnt_c   = CMP_W'(count);
  assign pos_c   = CMP_W'(position);
  assign last_c  = CMP_W'(last_position);
  assign depth_c = CMP_W'(DEPTH);
  assign gap     = STEP_W'(last_position) - STEP_W'(position) + STEP_W'(1);

  // Keep the low WORD_BITS bits of the incoming word, zero-filled if wider.
  assign value_wide = {{WORD_BITS{1'b0}}, value};

  always_comb begin
    dec_target = pos_c;
    dec_up     = 1'b0;
    dec_down   = 1'b0;
    dec_read   = 1'b0;
    dec_steps  = STEP_W'(1);
    dec_status = STAT_OK;
    dec_count  = cnt_c;
    unique case (cmd)
      CMD_APPEND: begin
        // Appending is an insert at the end of the list.
        dec_target = cnt_c;
        if (cnt_c >= depth_c) begin
          dec_status = STAT_FULL;
        end else begin
          dec_up    = 1'b1;
          dec_count = cnt_c + CMP_W'(1);
        end
      end
      CMD_REMOVE_LAST: begin
        if (cnt_c == '0) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_count = cnt_c - CMP_W'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_c > cnt_c) begin
          dec_status = STAT_RANGE;
        end else if (cnt_c >= depth_c) begin
          dec_status = STAT_FULL;
        end else begin
          dec_up    = 1'b1;
          dec_count = cnt_c + CMP_W'(1);
        end
      end
      CMD_ERASE_ONE: begin
        if (cnt_c == '0) begin
          dec_status = STAT_EMPTY;
        end else if (pos_c >= cnt_c) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_down  = 1'b1;
          dec_count = cnt_c - CMP_W'(1);
        end
      end
      CMD_ERASE_RANGE: begin
        if (cnt_c == '0) begin
          dec_status = STAT_EMPTY;
        end else if ((pos_c > last_c) || (last_c >= cnt_c)) begin
          dec_status = STAT_RANGE;
        end else begin
          // One shift down per removed entry.
          dec_down  = 1'b1;
          dec_steps = gap;
          dec_count = cnt_c - CMP_W'(gap);
        end
      end
      CMD_READ: begin
        if (cnt_c == '0) begin
          dec_status = STAT_EMPTY;
        end else if (pos_c >= cnt_c) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_read = 1'b1;
        end
      end
      CMD_CLEAR: begin
        dec_count = '0;
      end
      CMD_NOP: begin
        dec_status = STAT_OK;
      end
      default: begin
        dec_status = STAT_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller: next state and outputs in separate blocks.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (steps == STEP_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    last_step  = 1'b0;
    shift.up   = 1'b0;
    shift.down = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_EXEC: begin
        busy       = 1'b1;
        last_step  = (steps == STEP_W'(1));
        shift.up   = up_op;
        shift.down = down_op;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The request is held for the whole execute phase.
  always_ff @(posedge clk) begin
    if (accept) begin
      target        <= dec_target;
      new_word      <= value_wide[WORD_BITS-1:0];
      up_op         <= dec_up;
      down_op       <= dec_down;
      read_op       <= dec_read;
      result_status <= dec_status;
      count_after   <= CNT_W'(dec_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      steps <= dec_steps;
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Row of cells. Each cell sees its two neighbors; the ends see zeros, which
  // only ever land beyond the end of the list.
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0] cell_word [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_inner_l
      assign left_word = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_r
      assign right_word = cell_word[g+1];
    end

    oai_cell #(
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W),
      .INDEX     (g)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .target     (target),
      .new_word   (new_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Read path: a select over at most the first sixteen cells. A read never shifts,
  // so the row is stable while the word is picked.
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0]         rd_word;
  logic [WORD_BITS+VALUE_W-1:0] rd_wide;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (target == CMP_W'(i)) begin
        rd_word = cell_word[i];
      end
    end
  end

  assign rd_wide = {{VALUE_W{1'b0}}, rd_word};

  // ---------------------------------------------------------------------------
  // Count and result registers. The count moves to its new value on the last
  // step, together with the result strobe.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= last_step;
      if (last_step) begin
        count <= count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_step) begin
      read_value  <= read_op ? rd_wide[VALUE_W-1:0] : '0;
      entry_count <= COUNT_W'(count_after);
      status      <= result_status;
    end
  end

endmodule

[hw/rtl/oai_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array storage cell
// Holds one list entry and, on a shift step, takes its new word from itself,
// the new value, or one of its two neighbors.
// ----------------------------------------------------------------------------
module oai_cell
  import oai_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int CMP_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  shift_ctrl_t          shift,
  input  logic [CMP_W-1:0]     target,
  input  logic [WORD_BITS-1:0] new_word,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  output logic [WORD_BITS-1:0] word
);

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [WORD_BITS-1:0] word_next;

  always_comb begin
    word_next = word;
    if (shift.up) begin
      if (IDX == target) begin
        word_next = new_word;
      end else if (IDX > target) begin
        word_next = left_word;
      end
    end else if (shift.down) begin
      if (IDX >= target) begin
        word_next = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule
